[rtl/core/aups_pkg.sv]
// ----------------------------------------------------------------------------
// Angle unwrap position and speed package
// Field widths, register indexes, reset values and shared payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package aups_pkg;

   // Field and state widths.
   localparam int ANGLE_W    = 12;
   localparam int TIME_W     = 32;
   localparam int POS_W      = 32;
   localparam int SPEED_W    = 32;
   localparam int SUM_W      = 24;
   localparam int FILL_W     = 8;
   localparam int THR_W      = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_ADDR_W = 1;

   // Magnitude of window sum times the speed scale fits in this many bits.
   localparam int DIVIDEND_W = 34;

   // Speed is given in counts per second from millisecond time.
   localparam int SPEED_SCALE = 1000;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_JUMP_THRESHOLD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SAMPLES = 1'b1;

   // Register reset values.
   localparam logic [THR_W-1:0]  JUMP_THRESHOLD_RESET = 12'd2000;
   localparam logic [FILL_W-1:0] WINDOW_SAMPLES_RESET = 8'd10;

   typedef logic [ANGLE_W-1:0]    angle_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [SPEED_W-1:0]    speed_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

endpackage

`default_nettype wire

[rtl/core/aups_req_if.sv]
// ----------------------------------------------------------------------------
// Angle sample request channel
// Valid/ready channel that carries one angle sample and its time stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface aups_req_if;
   import aups_pkg::*;

   logic      valid;
   logic      ready;
   angle_type raw_angle;
   time_type  now_ms;

   modport source (output valid, output raw_angle, output now_ms, input ready);
   modport sink   (input valid, input raw_angle, input now_ms, output ready);
endinterface

`default_nettype wire

[rtl/core/aups_rsp_if.sv]
// ----------------------------------------------------------------------------
// Position and speed response channel
// Valid/ready channel that carries the position and speed for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface aups_rsp_if;
   import aups_pkg::*;

   logic      valid;
   logic      ready;
   pos_type   position_count;
   speed_type speed_rate;
   logic      speed_updated;

   modport source (output valid, output position_count, output speed_rate,
                   output speed_updated, input ready);
   modport sink   (input valid, input position_count, input speed_rate,
                   input speed_updated, output ready);
endinterface

`default_nettype wire

[rtl/core/angle_unwrap_position_speed.sv]
// ----------------------------------------------------------------------------
// Angle unwrap with position and windowed speed
// Unwraps absolute angle samples into a position and computes a speed over
// windows of samples with a bit-serial datapath and a restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one item: a raw angle and the millisecond time.
//   The rsp channel returns one item per request: the position, the latest
//   speed and a flag that is set when this sample closed a speed window.
//   The csr port writes the jump threshold and the window length.
// Sequence:
//   An item is accepted in the idle state, then the position, window sum
//   and elapsed time are updated one bit per cycle. A sample that closes
//   a window with nonzero elapsed time then passes the magnitude, the
//   scaling multiply, a 34-step restoring divider and the saturation.
//   Last the item loads the output register; only then is a new item
//   accepted.
// Reset and stalls:
//   Reset clears control and block state and sets registers to defaults.
//   A finished item waits in the output register; the block already works
//   on the next item and holds it in the last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_unwrap_position_speed #(
   parameter int COUNTS_PER_TURN = 4096
) (
   input  wire                    clock,
   input  wire                    reset,
   aups_req_if.sink               req,
   aups_rsp_if.source             rsp,
   input  wire                    csr_wen,
   input  aups_pkg::csr_addr_type csr_addr,
   input  aups_pkg::csr_data_type csr_wdata
);
   import aups_pkg::*;

   // Delta holds a raw difference or one corrected by a turn.
   localparam int TURN_W  = $clog2(COUNTS_PER_TURN + 1) + 1;
   localparam int DELTA_W = (TURN_W > ANGLE_W + 1) ? TURN_W : ANGLE_W + 1;
   localparam int CNT_W   = $clog2(DIVIDEND_W);

   localparam logic [CNT_W-1:0] SERIAL_LAST = CNT_W'(POS_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIVIDEND_W - 1);
   localparam logic [CNT_W-1:0] SUM_BITS    = CNT_W'(SUM_W);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SERIAL = 3'd1;
   localparam logic [2:0] ST_ABS    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_SAT    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [FILL_W-1:0]      samples_ff, samples_in;
   angle_type              prev_ff, prev_in;
   pos_type                pos_ff, pos_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   time_type               start_ff, start_in;
   speed_type              speed_ff, speed_in;
   time_type               now_ff, now_in;
   time_type               elapsed_ff, elapsed_in;
   logic [DELTA_W-1:0]     delta_ff, delta_in;
   logic                   close_ff, close_in;
   logic                   nonzero_ff, nonzero_in;
   logic                   pos_c_ff, pos_c_in;
   logic                   sum_c_ff, sum_c_in;
   logic                   borrow_ff, borrow_in;
   logic                   neg_ff, neg_in;
   logic [SUM_W-1:0]       mag_ff, mag_in;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [TIME_W-1:0]      rem_ff, rem_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pos_type                rsp_pos_ff, rsp_pos_in;
   speed_type              rsp_speed_ff, rsp_speed_in;
   logic                   rsp_upd_ff, rsp_upd_in;

   logic                   req_fire;
   logic                   out_free;
   logic signed [DELTA_W-1:0] dif;
   logic signed [DELTA_W-1:0] thr_s;
   logic signed [DELTA_W-1:0] delta_calc;
   logic [FILL_W-1:0]      ws;
   logic                   close_calc;
   logic                   pos_bit, sum_bit, e_bit;
   logic [TIME_W:0]        trial;
   logic [TIME_W:0]        trial_diff;

   assign req_fire  = req.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.position_count = rsp_pos_ff;
   assign rsp.speed_rate     = rsp_speed_ff;
   assign rsp.speed_updated  = rsp_upd_ff;

   // Turn unwrap of the raw difference and window close decision.
   always_comb begin
      dif   = signed'(DELTA_W'(req.raw_angle)) - signed'(DELTA_W'(prev_ff));
      thr_s = signed'(DELTA_W'(thr_ff));
      if (dif < -thr_s) begin
         delta_calc = dif + signed'(DELTA_W'(COUNTS_PER_TURN));
      end else if (dif > thr_s) begin
         delta_calc = dif - signed'(DELTA_W'(COUNTS_PER_TURN));
      end else begin
         delta_calc = dif;
      end
      ws         = (samples_ff == '0) ? FILL_W'(1) : samples_ff;
      close_calc = ({1'b0, fill_ff} + 9'd1) >= {1'b0, ws};
   end

   // Serial adder bits, serial subtractor bit and divider trial.
   always_comb begin
      pos_bit    = pos_ff[0] ^ delta_ff[0] ^ pos_c_ff;
      sum_bit    = sum_ff[0] ^ delta_ff[0] ^ sum_c_ff;
      e_bit      = now_ff[0] ^ start_ff[0] ^ borrow_ff;
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_diff = trial - {1'b0, elapsed_ff};
   end

   // Next-state logic of the sequencer and datapath.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      thr_in       = thr_ff;
      samples_in   = samples_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      start_in     = start_ff;
      speed_in     = speed_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      delta_in     = delta_ff;
      close_in     = close_ff;
      nonzero_in   = nonzero_ff;
      pos_c_in     = pos_c_ff;
      sum_c_in     = sum_c_ff;
      borrow_in    = borrow_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_upd_in   = rsp_upd_ff;

      // Configuration writes must arrive while idle; the block does not check.
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_JUMP_THRESHOLD: thr_in     = csr_wdata;
            CSR_WINDOW_SAMPLES: samples_in = csr_wdata[FILL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               delta_in   = delta_calc;
               prev_in    = req.raw_angle;
               now_in     = req.now_ms;
               close_in   = close_calc;
               cnt_in     = '0;
               pos_c_in   = 1'b0;
               sum_c_in   = 1'b0;
               borrow_in  = 1'b0;
               nonzero_in = 1'b0;
               state_in   = ST_SERIAL;
            end
         end
         // One bit per cycle: position, window sum and elapsed time.
         ST_SERIAL: begin
            pos_in   = {pos_bit, pos_ff[POS_W-1:1]};
            pos_c_in = (pos_ff[0] & delta_ff[0]) | (pos_ff[0] & pos_c_ff)
                     | (delta_ff[0] & pos_c_ff);
            if (cnt_ff < SUM_BITS) begin
               sum_in   = {sum_bit, sum_ff[SUM_W-1:1]};
               sum_c_in = (sum_ff[0] & delta_ff[0]) | (sum_ff[0] & sum_c_ff)
                        | (delta_ff[0] & sum_c_ff);
            end
            elapsed_in = {e_bit, elapsed_ff[TIME_W-1:1]};
            borrow_in  = (~now_ff[0] & start_ff[0])
                       | (~(now_ff[0] ^ start_ff[0]) & borrow_ff);
            nonzero_in = nonzero_ff | e_bit;
            now_in     = {now_ff[0], now_ff[TIME_W-1:1]};
            start_in   = {start_ff[0], start_ff[TIME_W-1:1]};
            delta_in   = {delta_ff[DELTA_W-1], delta_ff[DELTA_W-1:1]};
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == SERIAL_LAST) begin
               state_in = (close_ff && nonzero_in) ? ST_ABS : ST_OUT;
            end
         end
         // Sign and magnitude of the window sum.
         ST_ABS: begin
            neg_in   = sum_ff[SUM_W-1];
            mag_in   = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            quo_in   = DIVIDEND_W'(mag_ff) * DIVIDEND_W'(SPEED_SCALE);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         // Restoring division, one quotient bit per cycle.
         ST_DIV: begin
            if (!trial_diff[TIME_W]) begin
               rem_in = trial_diff[TIME_W-1:0];
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
            end else begin
               rem_in = trial[TIME_W-1:0];
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end
         end
         // Apply the sign and saturate to the signed speed range.
         ST_SAT: begin
            if (!neg_ff) begin
               if (quo_ff[DIVIDEND_W-1:SPEED_W-1] != '0) begin
                  speed_in = {1'b0, {(SPEED_W-1){1'b1}}};
               end else begin
                  speed_in = quo_ff[SPEED_W-1:0];
               end
            end else begin
               if ((quo_ff[DIVIDEND_W-1:SPEED_W] != '0) ||
                   (quo_ff[SPEED_W-1] && (quo_ff[SPEED_W-2:0] != '0))) begin
                  speed_in = {1'b1, {(SPEED_W-1){1'b0}}};
               end else begin
                  speed_in = ~quo_ff[SPEED_W-1:0] + SPEED_W'(1);
               end
            end
            state_in = ST_OUT;
         end
         // Load the output register and close or advance the window.
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_speed_in = speed_ff;
               rsp_upd_in   = close_ff;
               if (close_ff) begin
                  sum_in   = '0;
                  fill_in  = '0;
                  start_in = now_ff;
               end else begin
                  fill_in  = fill_ff + FILL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and block state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         thr_ff       <= JUMP_THRESHOLD_RESET;
         samples_ff   <= WINDOW_SAMPLES_RESET;
         prev_ff      <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         start_ff     <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         thr_ff       <= thr_in;
         samples_ff   <= samples_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         start_ff     <= start_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      elapsed_ff   <= elapsed_in;
      delta_ff     <= delta_in;
      close_ff     <= close_in;
      nonzero_ff   <= nonzero_in;
      pos_c_ff     <= pos_c_in;
      sum_c_ff     <= sum_c_in;
      borrow_ff    <= borrow_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

endmodule

`default_nettype wire
